/* hw/rtl/vmc_pkg.sv */
// vmc_pkg: shared types and widths for the vector magnitude clamp
// depends on nothing; used by the interfaces, the cells and the top level
package vmc_pkg;

  localparam int COMP_W  = 16;
  localparam int SQ_W    = 2 * COMP_W;
  localparam int ROOT_W  = COMP_W;
  localparam int REM_W   = ROOT_W + 1;
  localparam int N_STEPS = ROOT_W;

  // vector components and flag carried beside the arithmetic
  typedef struct packed {
    logic [COMP_W-1:0] x;
    logic [COMP_W-1:0] y;
    logic [COMP_W-1:0] z;
    logic              clamped;
  } vmc_side_t;

  // square root state of one item
  typedef struct packed {
    logic [SQ_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } vmc_sq_t;

  // products waiting for the divider
  typedef struct packed {
    logic [SQ_W-1:0] px;
    logic [SQ_W-1:0] py;
    logic [SQ_W-1:0] pz;
  } vmc_prod_t;

  // one divider lane: partial remainder and numerator/quotient shift word
  typedef struct packed {
    logic [COMP_W-1:0] rem;
    logic [COMP_W-1:0] nq;
  } vmc_lane_t;

  typedef struct packed {
    logic [ROOT_W-1:0] d;
    vmc_lane_t         lx;
    vmc_lane_t         ly;
    vmc_lane_t         lz;
  } vmc_div_t;

endpackage

/* hw/rtl/vmc_in_if.sv */
// vmc_in_if: input item channel of the vector magnitude clamp
// depends on vmc_pkg
interface vmc_in_if;
  logic                      valid;
  logic                      ready;
  logic [vmc_pkg::COMP_W-1:0] comp_x;
  logic [vmc_pkg::COMP_W-1:0] comp_y;
  logic [vmc_pkg::COMP_W-1:0] comp_z;

  modport source(output valid, comp_x, comp_y, comp_z, input ready);
  modport sink(input valid, comp_x, comp_y, comp_z, output ready);
endinterface

/* hw/rtl/vmc_out_if.sv */
// vmc_out_if: result item channel of the vector magnitude clamp
// depends on vmc_pkg
interface vmc_out_if;
  logic                      valid;
  logic                      ready;
  logic [vmc_pkg::COMP_W-1:0] out_x;
  logic [vmc_pkg::COMP_W-1:0] out_y;
  logic [vmc_pkg::COMP_W-1:0] out_z;
  logic                      was_clamped;

  modport source(output valid, out_x, out_y, out_z, was_clamped, input ready);
  modport sink(input valid, out_x, out_y, out_z, was_clamped, output ready);
endinterface

/* hw/rtl/vector_magnitude_clamp.sv */
// Vector magnitude clamp: limits the length of a signed Q8.8 3D vector to
// max_length. Takes one item per clock while not stalled and delivers one
// result per item, in order, through squares, compare, 16 square-root cells,
// 16 divider cells and the output register. The cell chain advances whenever
// it is not stalled. A two-entry output buffer keeps the input open while one
// result waits; the chain stalls only when both entries are full.
// depends on vmc_pkg, vmc_in_if, vmc_out_if, vmc_sqrt_cell, vmc_div_cell
module vector_magnitude_clamp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [vmc_pkg::COMP_W-1:0] cfg_wdata,
  vmc_in_if.sink                     in_ch,
  vmc_out_if.source                  out_ch
);

  localparam int W = vmc_pkg::COMP_W;
  localparam int N = vmc_pkg::N_STEPS;

  logic [W-1:0] max_length_r;
  logic         en;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= '1;
    end else if (cfg_we) begin
      max_length_r <= cfg_wdata;
    end
  end

  // stage a: squares and products
  logic [W-1:0]               mag_x, mag_y, mag_z;
  logic                       a_vld_r;
  logic [W-1:0]               a_x_r, a_y_r, a_z_r;
  logic [vmc_pkg::SQ_W-1:0]   a_sx_r, a_sy_r, a_sz_r, a_msq_r;
  vmc_pkg::vmc_prod_t         a_prod_r;

  assign mag_x = in_ch.comp_x[W-1] ? W'(~in_ch.comp_x + 1'b1) : in_ch.comp_x;
  assign mag_y = in_ch.comp_y[W-1] ? W'(~in_ch.comp_y + 1'b1) : in_ch.comp_y;
  assign mag_z = in_ch.comp_z[W-1] ? W'(~in_ch.comp_z + 1'b1) : in_ch.comp_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r       <= in_ch.comp_x;
      a_y_r       <= in_ch.comp_y;
      a_z_r       <= in_ch.comp_z;
      a_sx_r      <= mag_x * mag_x;
      a_sy_r      <= mag_y * mag_y;
      a_sz_r      <= mag_z * mag_z;
      a_msq_r     <= max_length_r * max_length_r;
      a_prod_r.px <= max_length_r * mag_x;
      a_prod_r.py <= max_length_r * mag_y;
      a_prod_r.pz <= max_length_r * mag_z;
    end
  end

  // stage b: length compare and root seed
  logic [vmc_pkg::SQ_W-1:0] sum_sq;
  logic                     b_vld_r;
  vmc_pkg::vmc_sq_t         b_sq_r;
  vmc_pkg::vmc_prod_t       b_prod_r;
  vmc_pkg::vmc_side_t       b_side_r;

  assign sum_sq = a_sx_r + a_sy_r + a_sz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sq_r.rad       <= sum_sq;
      b_sq_r.rem       <= '0;
      b_sq_r.root      <= '0;
      b_prod_r         <= a_prod_r;
      b_side_r.x       <= a_x_r;
      b_side_r.y       <= a_y_r;
      b_side_r.z       <= a_z_r;
      b_side_r.clamped <= sum_sq > a_msq_r;
    end
  end

  // square root chain
  logic               s_vld [N+1];
  vmc_pkg::vmc_sq_t   s_sq  [N+1];
  vmc_pkg::vmc_prod_t s_prod[N+1];
  vmc_pkg::vmc_side_t s_side[N+1];

  assign s_vld[0]  = b_vld_r;
  assign s_sq[0]   = b_sq_r;
  assign s_prod[0] = b_prod_r;
  assign s_side[0] = b_side_r;

  for (genvar i = 0; i < N; i++) begin : g_sqrt
    vmc_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (s_vld[i]),
      .sq_i  (s_sq[i]),
      .prod_i(s_prod[i]),
      .side_i(s_side[i]),
      .vld_o (s_vld[i+1]),
      .sq_o  (s_sq[i+1]),
      .prod_o(s_prod[i+1]),
      .side_o(s_side[i+1])
    );
  end

  // divider chain, seeded with the root as divisor
  logic               d_vld [N+1];
  vmc_pkg::vmc_div_t  d_dv  [N+1];
  vmc_pkg::vmc_side_t d_side[N+1];

  assign d_vld[0]     = s_vld[N];
  assign d_side[0]    = s_side[N];
  assign d_dv[0].d    = s_sq[N].root;
  assign d_dv[0].lx   = s_prod[N].px;
  assign d_dv[0].ly   = s_prod[N].py;
  assign d_dv[0].lz   = s_prod[N].pz;

  for (genvar i = 0; i < N; i++) begin : g_div
    vmc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (d_vld[i]),
      .dv_i  (d_dv[i]),
      .side_i(d_side[i]),
      .vld_o (d_vld[i+1]),
      .dv_o  (d_dv[i+1]),
      .side_o(d_side[i+1])
    );
  end

  // result select: pass through or signed quotient
  vmc_pkg::vmc_side_t res, out_r, skid_r;
  logic               out_v_r, skid_v_r, take;
  vmc_pkg::vmc_side_t last;

  assign last = d_side[N];

  always_comb begin
    res.clamped = last.clamped;
    if (last.clamped) begin
      res.x = last.x[W-1] ? W'(~d_dv[N].lx.nq + 1'b1) : d_dv[N].lx.nq;
      res.y = last.y[W-1] ? W'(~d_dv[N].ly.nq + 1'b1) : d_dv[N].ly.nq;
      res.z = last.z[W-1] ? W'(~d_dv[N].lz.nq + 1'b1) : d_dv[N].lz.nq;
    end else begin
      res.x = last.x;
      res.y = last.y;
      res.z = last.z;
    end
  end

  // output register and skid entry
  assign en   = !skid_v_r;
  assign take = out_ch.ready || !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= d_vld[N];
      end
    end else if (d_vld[N] && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (en) begin
      skid_r <= res;
    end
  end

  assign in_ch.ready        = en;
  assign out_ch.valid       = out_v_r;
  assign out_ch.out_x       = out_r.x;
  assign out_ch.out_y       = out_r.y;
  assign out_ch.out_z       = out_r.z;
  assign out_ch.was_clamped = out_r.clamped;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid entry full while output empty");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_r))
    else $error("waiting result changed");

  a_pass_unclamped: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld[N] && !last.clamped |-> res.x == last.x && res.y == last.y && res.z == last.z)
    else $error("unclamped item altered");

endmodule

/* hw/rtl/vmc_sqrt_cell.sv */
// vmc_sqrt_cell: one digit of the floor square root, registered
// depends on vmc_pkg
module vmc_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  vmc_pkg::vmc_sq_t   sq_i,
  input  vmc_pkg::vmc_prod_t prod_i,
  input  vmc_pkg::vmc_side_t side_i,
  output logic               vld_o,
  output vmc_pkg::vmc_sq_t   sq_o,
  output vmc_pkg::vmc_prod_t prod_o,
  output vmc_pkg::vmc_side_t side_o
);

  logic [vmc_pkg::REM_W+1:0] rem_s;
  logic [vmc_pkg::REM_W+1:0] trial;
  logic                      ge;
  vmc_pkg::vmc_sq_t          sq_nxt;
  logic                      vld_r;
  vmc_pkg::vmc_sq_t          sq_r;
  vmc_pkg::vmc_prod_t        prod_r;
  vmc_pkg::vmc_side_t        side_r;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_s       = {sq_i.rem, sq_i.rad[vmc_pkg::SQ_W-1 -: 2]};
    trial       = {1'b0, sq_i.root, 2'b01};
    ge          = rem_s >= trial;
    sq_nxt.rad  = {sq_i.rad[vmc_pkg::SQ_W-3:0], 2'b00};
    sq_nxt.rem  = ge ? vmc_pkg::REM_W'(rem_s - trial) : vmc_pkg::REM_W'(rem_s);
    sq_nxt.root = {sq_i.root[vmc_pkg::ROOT_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r   <= sq_nxt;
      prod_r <= prod_i;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign sq_o   = sq_r;
  assign prod_o = prod_r;
  assign side_o = side_r;

endmodule

/* hw/rtl/vmc_div_cell.sv */
// vmc_div_cell: one quotient bit for each of the three components, registered
// depends on vmc_pkg
module vmc_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  vmc_pkg::vmc_div_t  dv_i,
  input  vmc_pkg::vmc_side_t side_i,
  output logic               vld_o,
  output vmc_pkg::vmc_div_t  dv_o,
  output vmc_pkg::vmc_side_t side_o
);

  vmc_pkg::vmc_div_t  dv_nxt;
  logic               vld_r;
  vmc_pkg::vmc_div_t  dv_r;
  vmc_pkg::vmc_side_t side_r;

  // restoring step for one lane
  function automatic vmc_pkg::vmc_lane_t lane_step(vmc_pkg::vmc_lane_t l,
                                                   logic [vmc_pkg::ROOT_W-1:0] d);
    logic [vmc_pkg::COMP_W:0] s;
    logic                     ge;
    vmc_pkg::vmc_lane_t       r;
    s     = {l.rem, l.nq[vmc_pkg::COMP_W-1]};
    ge    = s >= {1'b0, d};
    r.rem = ge ? vmc_pkg::COMP_W'(s - {1'b0, d}) : vmc_pkg::COMP_W'(s);
    r.nq  = {l.nq[vmc_pkg::COMP_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    dv_nxt.d  = dv_i.d;
    dv_nxt.lx = lane_step(dv_i.lx, dv_i.d);
    dv_nxt.ly = lane_step(dv_i.ly, dv_i.d);
    dv_nxt.lz = lane_step(dv_i.lz, dv_i.d);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r   <= dv_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign dv_o   = dv_r;
  assign side_o = side_r;

endmodule
